### design/wsts_pkg.sv
package wsts_pkg;

	// Parser phases, one-hot.
	typedef enum logic [5:0] {
		PH_HEADER = 6'b000001,
		PH_CHUNK  = 6'b000010,
		PH_BODY   = 6'b000100,
		PH_PAD    = 6'b001000,
		PH_DATA   = 6'b010000,
		PH_DRAIN  = 6'b100000
	} phase_t;

	typedef enum logic [1:0] {
		KIND_AUDIO = 2'd0,
		KIND_OK    = 2'd1,
		KIND_ERR   = 2'd2
	} kind_t;

	localparam logic [23:0] TAG_FMT = 24'h746D66;
	localparam logic [23:0] TAG_DAT = 24'h746164;

	localparam logic [31:0] RATE_DEFAULT  = 32'd48000;
	localparam logic [31:0] RATE_MIN      = 32'd8000;
	localparam logic [15:0] CHANNELS_DEFAULT = 16'd2;
	localparam logic [15:0] BITS_DEFAULT  = 16'd16;
	localparam logic [15:0] CHANNELS_MONO = 16'd1;
	localparam logic [15:0] BITS_BYTE     = 16'd8;
	localparam logic [31:0] FMT_MIN_LEN   = 32'd16;

	typedef struct packed {
		kind_t              kind;
		logic signed [15:0] left_sample;
		logic signed [15:0] right_sample;
		logic [15:0]        sample_rate;
		logic               final_res;
	} result_t;

	// Up to two results written to the result queue in one cycle.
	// The second slot is only used when the first one is used too.
	typedef struct packed {
		logic    v0;
		result_t r0;
		logic    v1;
		result_t r1;
	} push_t;

	// Expected bytes of the RIFF file header ("RIFF" .... "WAVE").
	function automatic logic [7:0] hdr_expect(input logic [3:0] idx);
		logic [7:0] val;
		case (idx)
			4'd0: val = 8'h52;
			4'd1: val = 8'h49;
			4'd2: val = 8'h46;
			4'd3: val = 8'h46;
			4'd8: val = 8'h57;
			4'd9: val = 8'h41;
			4'd10: val = 8'h56;
			4'd11: val = 8'h45;
			default: val = 8'h00;
		endcase
		return val;
	endfunction

endpackage

### design/wsts_stream_if.sv
interface wsts_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_file;

	modport source (output valid, output in_byte, output end_of_file, input ready);
	modport sink (input valid, input in_byte, input end_of_file, output ready);
endinterface

interface wsts_result_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic signed [15:0] left_sample;
	logic signed [15:0] right_sample;
	logic [15:0]        sample_rate;
	logic               final_res;

	modport source (output valid, output kind, output left_sample, output right_sample,
		output sample_rate, output final_res, input ready);
	modport sink (input valid, input kind, input left_sample, input right_sample,
		input sample_rate, input final_res, output ready);
endinterface

### design/wsts_parser.sv
module wsts_parser import wsts_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] in_byte,
	input  logic       end_of_file,
	output push_t      push
);

	phase_t      phase_q, phase_d;
	logic [31:0] byte_count_q, byte_count_d;
	logic [23:0] chunk_tag_q, chunk_tag_d;
	logic [31:0] chunk_length_q, chunk_length_d;
	logic [15:0] channel_count_q, channel_count_d;
	logic [31:0] rate_hz_q, rate_hz_d;
	logic [15:0] bit_depth_q, bit_depth_d;
	logic [31:0] frame_bytes_q, frame_bytes_d;
	logic [1:0]  frame_fill_q, frame_fill_d;

	logic [32:0] bc_inc;
	logic        bc_last;
	logic        stereo, byte_samples, frame_done;
	logic [1:0]  fill_last;
	logic [31:0] fb_new;
	logic [15:0] eff_rate;
	logic [15:0] left_raw, right_raw;
	logic        audio_v, step_fin_v, step_fin_ok, eof_fin_v, eof_fin_ok;
	logic        fin_v, fin_ok;
	result_t     audio_res, fin_res;

	assign bc_inc  = {1'b0, byte_count_q} + 33'd1;
	assign bc_last = bc_inc >= {1'b0, chunk_length_q};

	assign stereo       = channel_count_q != CHANNELS_MONO;
	assign byte_samples = bit_depth_q == BITS_BYTE;
	assign fill_last    = {~byte_samples & stereo, ~byte_samples | stereo};
	assign frame_done   = frame_fill_q >= fill_last;
	assign eff_rate     = (rate_hz_q < RATE_MIN || rate_hz_q > RATE_DEFAULT) ?
		RATE_DEFAULT[15:0] : rate_hz_q[15:0];

	always_comb begin
		case (frame_fill_q)
			2'd0: fb_new = frame_bytes_q | {24'h0, in_byte};
			2'd1: fb_new = frame_bytes_q | {16'h0, in_byte, 8'h0};
			2'd2: fb_new = frame_bytes_q | {8'h0, in_byte, 16'h0};
			default: fb_new = frame_bytes_q | {in_byte, 24'h0};
		endcase
	end

	always_comb begin
		if (byte_samples) begin
			left_raw  = {~fb_new[7], fb_new[6:0], 8'h00};
			right_raw = stereo ? {~fb_new[15], fb_new[14:8], 8'h00} : left_raw;
		end else begin
			left_raw  = fb_new[15:0];
			right_raw = stereo ? fb_new[31:16] : left_raw;
		end
	end

	always_comb begin
		phase_d         = phase_q;
		byte_count_d    = byte_count_q;
		chunk_tag_d     = chunk_tag_q;
		chunk_length_d  = chunk_length_q;
		channel_count_d = channel_count_q;
		rate_hz_d       = rate_hz_q;
		bit_depth_d     = bit_depth_q;
		frame_bytes_d   = frame_bytes_q;
		frame_fill_d    = frame_fill_q;
		audio_v         = 1'b0;
		step_fin_v      = 1'b0;
		step_fin_ok     = 1'b0;
		eof_fin_v       = 1'b0;
		eof_fin_ok      = 1'b0;

		case (phase_q)
			PH_HEADER: begin
				if ((byte_count_q[3:0] inside {[4'd0:4'd3], [4'd8:4'd11]}) &&
					in_byte != hdr_expect(byte_count_q[3:0])) begin
					step_fin_v = 1'b1;
					phase_d    = PH_DRAIN;
				end else if (byte_count_q[3:0] == 4'd11) begin
					byte_count_d = '0;
					phase_d      = PH_CHUNK;
				end else begin
					byte_count_d = bc_inc[31:0];
				end
			end
			PH_CHUNK: begin
				case (byte_count_q[2:0])
					3'd0: chunk_tag_d[7:0] = in_byte;
					3'd1: chunk_tag_d[15:8] = in_byte;
					3'd2: chunk_tag_d[23:16] = in_byte;
					3'd4: chunk_length_d[7:0] = in_byte;
					3'd5: chunk_length_d[15:8] = in_byte;
					3'd6: chunk_length_d[23:16] = in_byte;
					3'd7: chunk_length_d[31:24] = in_byte;
					default: ;
				endcase
				if (byte_count_q[2:0] == 3'd7) begin
					byte_count_d = '0;
					if (chunk_tag_d == TAG_DAT) begin
						frame_bytes_d = '0;
						frame_fill_d  = '0;
						if (chunk_length_d == 32'd0) begin
							step_fin_v  = 1'b1;
							step_fin_ok = 1'b1;
							phase_d     = PH_DRAIN;
						end else begin
							phase_d = PH_DATA;
						end
					end else begin
						phase_d = (chunk_length_d == 32'd0) ? PH_CHUNK : PH_BODY;
					end
				end else begin
					byte_count_d = bc_inc[31:0];
				end
			end
			PH_BODY: begin
				if (chunk_tag_q == TAG_FMT && chunk_length_q >= FMT_MIN_LEN &&
					byte_count_q[31:4] == 28'd0) begin
					case (byte_count_q[3:0])
						4'd2: channel_count_d[7:0] = in_byte;
						4'd3: channel_count_d[15:8] = in_byte;
						4'd4: rate_hz_d[7:0] = in_byte;
						4'd5: rate_hz_d[15:8] = in_byte;
						4'd6: rate_hz_d[23:16] = in_byte;
						4'd7: rate_hz_d[31:24] = in_byte;
						4'd14: bit_depth_d[7:0] = in_byte;
						4'd15: bit_depth_d[15:8] = in_byte;
						default: ;
					endcase
				end
				if (bc_last) begin
					byte_count_d = '0;
					phase_d      = chunk_length_q[0] ? PH_PAD : PH_CHUNK;
				end else begin
					byte_count_d = bc_inc[31:0];
				end
			end
			PH_PAD: begin
				phase_d = PH_CHUNK;
			end
			PH_DATA: begin
				if (frame_done) begin
					audio_v       = 1'b1;
					frame_bytes_d = '0;
					frame_fill_d  = '0;
				end else begin
					frame_bytes_d = fb_new;
					frame_fill_d  = frame_fill_q + 2'd1;
				end
				byte_count_d = bc_inc[31:0];
				if (bc_last) begin
					step_fin_v  = 1'b1;
					step_fin_ok = 1'b1;
					phase_d     = PH_DRAIN;
				end
			end
			default: ;
		endcase

		if (end_of_file) begin
			if (phase_d == PH_DATA) begin
				eof_fin_v  = 1'b1;
				eof_fin_ok = 1'b1;
			end else if (phase_d != PH_DRAIN) begin
				eof_fin_v = 1'b1;
			end
			phase_d         = PH_HEADER;
			byte_count_d    = '0;
			chunk_tag_d     = '0;
			chunk_length_d  = '0;
			channel_count_d = CHANNELS_DEFAULT;
			rate_hz_d       = RATE_DEFAULT;
			bit_depth_d     = BITS_DEFAULT;
			frame_bytes_d   = '0;
			frame_fill_d    = '0;
		end
	end

	// At most one finish per byte: a finish from the step sends the parser
	// to the drain phase, where the end of the file adds nothing.
	assign fin_v  = step_fin_v | eof_fin_v;
	assign fin_ok = step_fin_v ? step_fin_ok : eof_fin_ok;

	always_comb begin
		audio_res.kind         = KIND_AUDIO;
		audio_res.left_sample  = left_raw;
		audio_res.right_sample = right_raw;
		audio_res.sample_rate  = eff_rate;
		audio_res.final_res    = 1'b0;

		fin_res.kind         = fin_ok ? KIND_OK : KIND_ERR;
		fin_res.left_sample  = '0;
		fin_res.right_sample = '0;
		fin_res.sample_rate  = fin_ok ? eff_rate : 16'd0;
		fin_res.final_res    = 1'b1;

		push.v0 = accept & (audio_v | fin_v);
		push.r0 = audio_v ? audio_res : fin_res;
		push.v1 = accept & audio_v & fin_v;
		push.r1 = fin_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_HEADER;
			byte_count_q    <= '0;
			chunk_tag_q     <= '0;
			chunk_length_q  <= '0;
			channel_count_q <= CHANNELS_DEFAULT;
			rate_hz_q       <= RATE_DEFAULT;
			bit_depth_q     <= BITS_DEFAULT;
			frame_bytes_q   <= '0;
			frame_fill_q    <= '0;
		end else if (accept) begin
			phase_q         <= phase_d;
			byte_count_q    <= byte_count_d;
			chunk_tag_q     <= chunk_tag_d;
			chunk_length_q  <= chunk_length_d;
			channel_count_q <= channel_count_d;
			rate_hz_q       <= rate_hz_d;
			bit_depth_q     <= bit_depth_d;
			frame_bytes_q   <= frame_bytes_d;
			frame_fill_q    <= frame_fill_d;
		end
	end

endmodule

### design/wsts_result_fifo.sv
module wsts_result_fifo import wsts_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  push_t   push,
	output logic    room,
	output result_t head,
	output logic    head_valid,
	input  logic    pop
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	result_t         mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q, wr_next, wr_next2;
	logic [CW-1:0]   count_q;
	logic            do_pop;

	function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign wr_next    = wrap_inc(wr_ptr_q);
	assign wr_next2   = wrap_inc(wr_next);
	assign head       = mem_q[rd_ptr_q];
	assign head_valid = count_q != '0;
	assign do_pop     = pop & head_valid;
	// Room for the two results that one byte can cause.
	assign room       = count_q <= CW'(DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.v1) begin
			mem_q[wr_next] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.v1) begin
				wr_ptr_q <= wr_next2;
			end else if (push.v0) begin
				wr_ptr_q <= wr_next;
			end
			if (do_pop) begin
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			end
			count_q <= count_q + CW'(push.v0) + CW'(push.v1) - CW'(do_pop);
		end
	end

endmodule

### design/wav_stream_to_stereo16.sv
// Streaming WAV parser: feed the file one byte per transaction on byte_chan, with
// end_of_file set on the last byte, and take 16-bit stereo frames plus exactly one
// finish result per file from result_chan. The block takes one byte every cycle;
// each byte is parsed in the cycle it is accepted and its results (none, one or two)
// go into a small result queue that drains at one result per cycle while the sink
// is ready. A byte that completes a frame and also ends the file yields two
// results, so byte_chan ready drops only while the queue has fewer than two free
// slots. There is no start-up pass after reset: the first byte can follow at once.
module wav_stream_to_stereo16 import wsts_pkg::*; #(
	// Result queue depth, at least 2; 4 or more keeps one byte per cycle while result_chan stays ready.
	parameter int RESULT_DEPTH = 4
) (
	input logic          clk,
	input logic          arst_n,
	wsts_byte_if.sink    byte_chan,
	wsts_result_if.source result_chan
);

	logic    accept;
	logic    room;
	push_t   push;
	result_t head;
	logic    head_valid;

	// A byte transaction completes when the queue can take its worst case.
	assign byte_chan.ready = room;
	assign accept          = byte_chan.valid & room;

	// The parser holds the file walk state: header check, chunk headers,
	// fmt fields, and the partial frame being assembled from data bytes.
	wsts_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.in_byte     (byte_chan.in_byte),
		.end_of_file (byte_chan.end_of_file),
		.push        (push)
	);

	// The result queue decouples the byte side from a stalled result sink.
	wsts_result_fifo #(
		.DEPTH (RESULT_DEPTH)
	) u_result_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.room       (room),
		.head       (head),
		.head_valid (head_valid),
		.pop        (result_chan.ready)
	);

	assign result_chan.valid        = head_valid;
	assign result_chan.kind         = head.kind;
	assign result_chan.left_sample  = head.left_sample;
	assign result_chan.right_sample = head.right_sample;
	assign result_chan.sample_rate  = head.sample_rate;
	assign result_chan.final_res    = head.final_res;

endmodule

### verif/wsts_frame_check.sv
`timescale 1ns / 100ps

module wsts_frame_check (
	input  logic        clk,
	input  logic        arst_n,
	wsts_byte_if        byte_chan,
	wsts_result_if      result_chan,
	output int unsigned pending,
	output int unsigned errors
);
	import wsts_pkg::*;

	// "RIFF" in bytes 0 to 3 and "WAVE" in bytes 8 to 11, byte 0 in the low bits.
	localparam logic [95:0] RIFF_WAVE = 96'h45564157_00000000_46464952;

	phase_t      ph;
	logic [31:0] pos;
	logic [23:0] tag;
	logic [31:0] clen;
	logic [15:0] chans;
	logic [31:0] rate;
	logic [15:0] bits;
	logic [31:0] fbytes;
	logic [1:0]  ffill;
	result_t     stereo_results_q[$];

	task automatic start_file();
		ph = PH_HEADER;
		pos = '0;
		tag = '0;
		clen = '0;
		chans = CHANNELS_DEFAULT;
		rate = RATE_DEFAULT;
		bits = BITS_DEFAULT;
		fbytes = '0;
		ffill = '0;
	endtask

	function automatic logic [15:0] play_rate();
		return (rate < RATE_MIN || rate > RATE_DEFAULT) ? RATE_DEFAULT[15:0] : rate[15:0];
	endfunction

	task automatic expect_result(input kind_t k, input logic [15:0] l, input logic [15:0] r,
			input logic [15:0] hz, input logic fin);
		result_t e;
		e.kind = k;
		e.left_sample = l;
		e.right_sample = r;
		e.sample_rate = hz;
		e.final_res = fin;
		stereo_results_q.push_back(e);
	endtask

	// Collects one data byte into the current frame and converts a full frame.
	task automatic add_sample_byte(input logic [7:0] b);
		logic        stereo;
		logic        wide;
		int          fsize;
		logic [15:0] l;
		logic [15:0] r;
		stereo = (chans != CHANNELS_MONO);
		wide = (bits != BITS_BYTE);
		fsize = (wide ? 2 : 1) * (stereo ? 2 : 1);
		fbytes = fbytes | (32'(b) << (8 * ffill));
		if (int'(ffill) + 1 < fsize) begin
			ffill = ffill + 2'd1;
			return;
		end
		if (!wide) begin
			l = {fbytes[7:0] ^ 8'h80, 8'h00};
			r = stereo ? {fbytes[15:8] ^ 8'h80, 8'h00} : l;
		end else begin
			l = fbytes[15:0];
			r = stereo ? fbytes[31:16] : l;
		end
		expect_result(KIND_AUDIO, l, r, play_rate(), 1'b0);
		fbytes = '0;
		ffill = '0;
	endtask

	task automatic take_fmt_byte(input logic [7:0] b);
		if (clen < FMT_MIN_LEN) begin
			return;
		end
		case (pos)
			32'd2: chans[7:0] = b;
			32'd3: chans[15:8] = b;
			32'd4: rate[7:0] = b;
			32'd5: rate[15:8] = b;
			32'd6: rate[23:16] = b;
			32'd7: rate[31:24] = b;
			32'd14: bits[7:0] = b;
			32'd15: bits[15:8] = b;
			default: ;
		endcase
	endtask

	task automatic parse_wav_byte(input logic [7:0] b, input logic eof);
		case (ph)
			PH_HEADER: begin
				if (pos < 12 && (pos < 4 || pos >= 8) && b != RIFF_WAVE[pos * 8 +: 8]) begin
					expect_result(KIND_ERR, '0, '0, '0, 1'b1);
					ph = PH_DRAIN;
				end else begin
					pos++;
					if (pos >= 12) begin
						pos = '0;
						ph = PH_CHUNK;
					end
				end
			end
			PH_CHUNK: begin
				if (pos < 3) begin
					tag[pos * 8 +: 8] = b;
				end else if (pos >= 4 && pos < 8) begin
					clen[(pos - 4) * 8 +: 8] = b;
				end
				pos++;
				if (pos >= 8) begin
					pos = '0;
					if (tag == TAG_DAT) begin
						fbytes = '0;
						ffill = '0;
						if (clen == 0) begin
							expect_result(KIND_OK, '0, '0, play_rate(), 1'b1);
							ph = PH_DRAIN;
						end else begin
							ph = PH_DATA;
						end
					end else begin
						ph = (clen == 0) ? PH_CHUNK : PH_BODY;
					end
				end
			end
			PH_BODY: begin
				if (tag == TAG_FMT) begin
					take_fmt_byte(b);
				end
				pos++;
				if (pos >= clen) begin
					pos = '0;
					ph = clen[0] ? PH_PAD : PH_CHUNK;
				end
			end
			PH_PAD: begin
				ph = PH_CHUNK;
			end
			PH_DATA: begin
				add_sample_byte(b);
				pos++;
				if (pos >= clen) begin
					expect_result(KIND_OK, '0, '0, play_rate(), 1'b1);
					ph = PH_DRAIN;
				end
			end
			default: ;
		endcase

		if (eof) begin
			if (ph == PH_DATA) begin
				expect_result(KIND_OK, '0, '0, play_rate(), 1'b1);
			end else if (ph != PH_DRAIN) begin
				expect_result(KIND_ERR, '0, '0, '0, 1'b1);
			end
			start_file();
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
		end
	endtask

	task automatic check_result();
		result_t want;
		if (stereo_results_q.size() == 0) begin
			errors++;
			$display("%0t: unexpected result, expected none, actual kind %0d left %h",
				$time, result_chan.kind, result_chan.left_sample);
			$display("%0t:   right %h rate %0d final %b", $time,
				result_chan.right_sample, result_chan.sample_rate, result_chan.final_res);
			return;
		end
		want = stereo_results_q.pop_front();
		check_field("kind", 16'(want.kind), 16'(result_chan.kind));
		check_field("left_sample", want.left_sample, result_chan.left_sample);
		check_field("right_sample", want.right_sample, result_chan.right_sample);
		check_field("sample_rate", want.sample_rate, result_chan.sample_rate);
		check_field("final_res", 16'(want.final_res), 16'(result_chan.final_res));
	endtask

	// Both channels are sampled at the clock edge, so the values seen are the ones
	// that were present when the transaction took place.
	always @(posedge clk) begin
		if (!arst_n) begin
			start_file();
			stereo_results_q.delete();
			pending = 0;
			errors = 0;
		end else begin
			if (byte_chan.valid && byte_chan.ready) begin
				parse_wav_byte(byte_chan.in_byte, byte_chan.end_of_file);
			end
			if (result_chan.valid && result_chan.ready) begin
				check_result();
			end
			pending = stereo_results_q.size();
		end
	end

endmodule

### verif/wav_stream_to_stereo16_tb.sv
`timescale 1ns / 100ps

// Top of the WAV parser bench. It builds WAV files byte by byte, sends them on
// the byte channel with end_of_file on the last byte of each file, and paces
// the result channel. All prediction and comparison happens in the checker,
// which reports its error count back here for the final verdict.
module wav_stream_to_stereo16_tb;
	import wsts_pkg::*;

	// Stop generating random files once this many bytes have gone out in total.
	localparam int unsigned RANDOM_BYTES = 1400;
	// Length of the long receiver hold-off that forces the result queue full.
	localparam int unsigned LONG_HOLD = 150;
	// Settling wait after the last result, before the final verdict.
	localparam int unsigned SETTLE_CYCLES = 20;
	// Which random file slot is replaced by the back-pressure file.
	localparam int unsigned HOLD_FILE = 12;

	// Pacing schemes for the two channels. GAP_HOLD keeps the receiver off for
	// the long hold-off while the sender pushes without gaps.
	typedef enum logic [2:0] {
		GAP_NONE,
		GAP_SENDER,
		GAP_RECEIVER,
		GAP_BOTH,
		GAP_HOLD
	} gap_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	gap_mode_t   gap_mode = GAP_NONE;
	int unsigned hold_count = 0;
	int unsigned pending;
	int unsigned errors;
	int unsigned bytes_sent = 0;
	// The file under construction, sent in one go by send_file.
	logic [7:0]  wav_q[$];

	wsts_byte_if   byte_chan ();
	wsts_result_if result_chan ();

	wav_stream_to_stereo16 dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_chan  (byte_chan),
		.result_chan(result_chan)
	);

	wsts_frame_check frame_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_chan  (byte_chan),
		.result_chan(result_chan),
		.pending    (pending),
		.errors     (errors)
	);

	always #10 clk = ~clk;

	function automatic int unsigned send_gap_pct(input gap_mode_t m);
		case (m)
			GAP_SENDER: return 62;
			GAP_BOTH: return 25;
			default: return 0;
		endcase
	endfunction

	function automatic int unsigned stall_pct(input gap_mode_t m);
		case (m)
			GAP_RECEIVER: return 62;
			GAP_BOTH: return 25;
			default: return 0;
		endcase
	endfunction

	// Receiver pacing. In hold mode this process counts the hold-off itself and
	// then keeps ready high so the queue drains and the stalled sender resumes. The mode
	// is only ever changed with nonblocking assignments, so the value seen here
	// at an edge is always the one from before that edge.
	always @(posedge clk) begin
		if (!arst_n) begin
			result_chan.ready <= 1'b0;
			hold_count <= 0;
		end else if (gap_mode == GAP_HOLD) begin
			if (hold_count < LONG_HOLD) begin
				hold_count <= hold_count + 1;
				result_chan.ready <= 1'b0;
			end else begin
				result_chan.ready <= 1'b1;
			end
		end else begin
			hold_count <= 0;
			result_chan.ready <= ($urandom_range(99) >= stall_pct(gap_mode));
		end
	end

	// File building helpers. Multi-byte fields of a WAV file are little-endian.
	task automatic put8(input logic [7:0] v);
		wav_q.push_back(v);
	endtask

	task automatic put16(input logic [15:0] v);
		put8(v[7:0]);
		put8(v[15:8]);
	endtask

	task automatic put32(input logic [31:0] v);
		put16(v[15:0]);
		put16(v[31:16]);
	endtask

	task automatic put_junk(input int unsigned n);
		repeat (n) put8(8'($urandom));
	endtask

	// "RIFF", a size field that the block ignores, "WAVE".
	task automatic put_riff();
		put32(32'h46464952);
		put32($urandom);
		put32(32'h45564157);
	endtask

	// A chunk header carries three tag bytes the block looks at, a fourth that
	// it ignores, and the 32-bit body size.
	task automatic put_chunk_head(input logic [23:0] tag, input logic [7:0] fourth,
			input logic [31:0] size);
		put8(tag[7:0]);
		put8(tag[15:8]);
		put8(tag[23:16]);
		put8(fourth);
		put32(size);
	endtask

	// A fmt chunk of the given size. Below 16 bytes the body is random and must
	// not change the format; above 16 the extra bytes are skipped. Odd sizes get
	// a pad byte.
	task automatic put_fmt(input logic [31:0] size, input logic [15:0] chans,
			input logic [31:0] rate, input logic [15:0] bits);
		put_chunk_head(TAG_FMT, 8'h20, size);
		if (size >= 16) begin
			put16(16'($urandom));
			put16(chans);
			put32(rate);
			put32($urandom);
			put16(16'($urandom));
			put16(bits);
			put_junk(size - 16);
		end else begin
			put_junk(size);
		end
		if (size[0]) begin
			put8(8'($urandom));
		end
	endtask

	// Mostly mono and stereo, with the odd illegal count that must fall back to stereo.
	function automatic logic [15:0] pick_channels();
		case ($urandom_range(5))
			0, 1, 2: return CHANNELS_MONO;
			3, 4: return CHANNELS_DEFAULT;
			default: return 16'($urandom);
		endcase
	endfunction

	// Rates on and just beyond both clamp limits, common rates, and wild values.
	function automatic logic [31:0] pick_rate();
		case ($urandom_range(9))
			0: return RATE_MIN;
			1: return RATE_DEFAULT;
			2: return RATE_MIN - 1;
			3: return RATE_DEFAULT + 1;
			4: return 32'd44100;
			5: return 32'd0;
			6: return 32'hFFFF_FFFF;
			7: return $urandom;
			default: return $urandom_range(RATE_DEFAULT, RATE_MIN);
		endcase
	endfunction

	function automatic logic [15:0] pick_bits();
		case ($urandom_range(5))
			0, 1, 2: return BITS_BYTE;
			3, 4: return BITS_DEFAULT;
			default: return 16'($urandom);
		endcase
	endfunction

	// One random file. Most are well formed so that the data phase is reached
	// with many format settings; a few have broken tags, huge chunks, no data
	// chunk, or are cut short by end_of_file.
	task automatic put_random_file();
		int unsigned roll;
		int unsigned n_data;
		int unsigned idx;
		int unsigned keep;
		logic [31:0] size;
		logic [23:0] tag;

		put_riff();
		if ($urandom_range(99) < 6) begin
			// Break one byte of either tag; the rest of the file must be ignored.
			idx = $urandom_range(7);
			idx = (idx < 4) ? idx : idx + 4;
			wav_q[idx] = wav_q[idx] ^ 8'($urandom_range(255, 1));
			put_junk($urandom_range(6));
			return;
		end

		// Chunks the parser has to skip, including odd sizes with their pad byte.
		repeat ($urandom_range(2)) begin
			tag = 24'($urandom);
			if (tag == TAG_FMT || tag == TAG_DAT) begin
				tag = tag ^ 24'd1;
			end
			if ($urandom_range(99) < 4) begin
				// A chunk far larger than the file: it ends inside the body.
				put_chunk_head(tag, 8'($urandom), 32'hFFFF_FFFF - $urandom_range(3));
				put_junk($urandom_range(8, 1));
				return;
			end
			size = $urandom_range(7);
			put_chunk_head(tag, 8'($urandom), size);
			put_junk(size);
			if (size[0]) begin
				put8(8'($urandom));
			end
		end

		if ($urandom_range(99) < 85) begin
			roll = $urandom_range(99);
			if (roll < 70) begin
				size = FMT_MIN_LEN;
			end else if (roll < 85) begin
				size = FMT_MIN_LEN + $urandom_range(5, 1);
			end else begin
				size = $urandom_range(15);
			end
			put_fmt(size, pick_channels(), pick_rate(), pick_bits());
			// Sometimes a second fmt chunk that must override the first.
			if ($urandom_range(9) == 0) begin
				put_fmt(FMT_MIN_LEN, pick_channels(), pick_rate(), pick_bits());
			end
		end

		if ($urandom_range(99) < 90) begin
			n_data = ($urandom_range(9) == 0) ? $urandom_range(48, 25) : $urandom_range(16, 1);
			roll = $urandom_range(99);
			if (roll < 55) begin
				size = n_data;
			end else if (roll < 70) begin
				size = n_data + $urandom_range(8, 1);
			end else if (roll < 80) begin
				size = 32'hFFFF_FFFF;
			end else if (roll < 90) begin
				size = 0;
			end else begin
				size = $urandom_range(n_data, 1);
			end
			put_chunk_head(TAG_DAT, 8'($urandom), size);
			put_junk(n_data);
			put_junk($urandom_range(3));
		end

		// Now and then the file is cut off anywhere.
		if ($urandom_range(99) < 5) begin
			keep = $urandom_range(wav_q.size(), 1);
			while (wav_q.size() > keep) begin
				void'(wav_q.pop_back());
			end
		end
	endtask

	// One transaction on the byte channel. valid stays high from one byte to
	// the next unless an idle gap is drawn, and ready is read right after the
	// edge, before any update that the edge causes takes effect.
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < send_gap_pct(gap_mode)) begin
			byte_chan.valid <= 1'b0;
			@(posedge clk);
		end
		byte_chan.valid <= 1'b1;
		byte_chan.in_byte <= b;
		byte_chan.end_of_file <= last;
		@(posedge clk);
		while (!byte_chan.ready) begin
			@(posedge clk);
		end
	endtask

	task automatic send_file();
		for (int i = 0; i < wav_q.size(); i++) begin
			send_byte(wav_q[i], i == wav_q.size() - 1);
		end
		bytes_sent += wav_q.size();
		wav_q.delete();
	endtask

	initial begin
		int unsigned file_idx;

		byte_chan.valid = 1'b0;
		byte_chan.in_byte = 8'h00;
		byte_chan.end_of_file = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Bad RIFF tag on the third byte, then a byte that must be ignored.
		put8(8'h52);
		put8(8'h49);
		put8(8'hFF);
		put8(8'h00);
		send_file();

		// Bad WAVE tag on its last byte.
		put_riff();
		wav_q[11] = 8'h00;
		put_junk(2);
		send_file();

		// Header only: the file ends without a data chunk.
		put_riff();
		send_file();

		// Data without any fmt chunk uses the default 16-bit stereo at 48 kHz.
		// The samples hit both signed extremes; the trailing byte is ignored.
		put_riff();
		put_chunk_head(TAG_DAT, 8'h61, 32'd8);
		put32(32'h7FFF_8000);
		put32(32'h0000_FFFF);
		put8(8'h5A);
		send_file();

		// 8-bit mono at the lowest rate; the file ends before the chunk size.
		put_riff();
		put_fmt(FMT_MIN_LEN, CHANNELS_MONO, RATE_MIN, BITS_BYTE);
		put_chunk_head(TAG_DAT, 8'h61, 32'd7);
		put32(32'h7FFF_8000);
		put8(8'h01);
		send_file();

		// 8-bit stereo, rate just above range, odd data size: the last data byte is a
		// dropped partial frame and also ends the chunk.
		put_riff();
		put_fmt(FMT_MIN_LEN, CHANNELS_DEFAULT, RATE_DEFAULT + 1, BITS_BYTE);
		put_chunk_head(TAG_DAT, 8'h61, 32'd3);
		put8(8'hFF);
		put8(8'h00);
		put8(8'h42);
		put8(8'h33);
		send_file();

		// Empty data chunk finishes on its header.
		put_riff();
		put_chunk_head(TAG_DAT, 8'h61, 32'd0);
		put_junk(2);
		send_file();

		// A skipped chunk with a pad byte, a short fmt chunk that changes
		// nothing, then a long one for 16-bit mono.
		put_riff();
		put_chunk_head(24'h53494C, 8'h54, 32'd3);
		put_junk(4);
		put_fmt(32'd15, CHANNELS_MONO, RATE_MIN, BITS_BYTE);
		put_fmt(32'd18, CHANNELS_MONO, 32'd16000, BITS_DEFAULT);
		put_chunk_head(TAG_DAT, 8'h61, 32'd4);
		put32(32'h7FFF_8000);
		send_file();

		// Illegal channel count, bit depth and rate all fall back to defaults.
		put_riff();
		put_fmt(FMT_MIN_LEN, 16'd3, RATE_MIN - 1, 16'd24);
		put_chunk_head(TAG_DAT, 8'h61, 32'd4);
		put32($urandom);
		send_file();

		// Random files, cycling through the pacing schemes every three files.
		// One slot carries a long 8-bit mono file sent against a receiver that
		// holds off, so the result queue fills and the byte channel stalls.
		// That slot is always reached, however short the random files turn out.
		file_idx = 0;
		while (bytes_sent < RANDOM_BYTES || file_idx <= HOLD_FILE) begin
			if (file_idx == HOLD_FILE) begin
				gap_mode <= GAP_HOLD;
				put_riff();
				put_fmt(FMT_MIN_LEN, CHANNELS_MONO, 32'd11025, BITS_BYTE);
				put_chunk_head(TAG_DAT, 8'h61, 32'd96);
				put_junk(96);
			end else begin
				gap_mode <= gap_mode_t'((file_idx / 3) % 4);
				put_random_file();
			end
			send_file();
			file_idx++;
		end
		byte_chan.valid <= 1'b0;

		// Let the checker see the last transaction, then wait for every result.
		@(posedge clk);
		wait (pending == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (errors == 0 && pending == 0) begin
			$display("wav_stream_to_stereo16 verification clean");
		end else begin
			$display("wav_stream_to_stereo16 verification failed");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run of this stimulus.
	initial begin
		#4_000_000;
		$display("wav_stream_to_stereo16 verification failed");
		$finish;
	end

endmodule
